>>> design/dtts_pkg.sv
// Package for the deadline timer task scheduler: opcodes, slot states, register indexes,
// controller command and status structures, and the wrapping-order helper.
// No dependencies; the datapath, controller and top level use it by scoped names.
package dtts_pkg;

	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;
	localparam logic [1:0] OP_SERVICE  = 2'd2;
	localparam logic [1:0] OP_OVERFLOW = 2'd3;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCHED = 2'd1;
	localparam logic [1:0] ST_CANC  = 2'd2;

	localparam logic CFG_SPIN   = 1'b0;
	localparam logic CFG_RELOAD = 1'b1;

	localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

	typedef struct packed {
		logic load;
		logic clr_fired;
		logic pos_clr;
		logic pos_inc;
		logic ord_remove;
		logic ord_insert;
		logic stk_remove;
		logic stk_push;
		logic wr_mem;
		logic set_cur_slot;
		logic rd_pos;
		logic set_cur_pos;
		logic rd_head;
		logic key_add_iv;
		logic div_start;
		logic mul;
		logic key_add_prod;
		logic wr_key;
		logic st_idle_cur;
		logic emit_canc;
		logic emit_exp;
		logic emit_status;
		logic ofs_add;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       slot_ok;
		logic [1:0] slot_stat;
		logic       pos_end;
		logic       ord_hit;
		logic       stk_hit;
		logic       stk_empty;
		logic       fired_pos;
		logic       rd_no_later;
		logic       due;
		logic       iv_zero;
		logic       wrap_need;
		logic       div_done;
		logic       can_emit;
	} stat_t;

	function automatic logic no_later(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = b - a;
		return diff <= HALF_RANGE;
	endfunction

endpackage

>>> design/dtts_if.sv
// Valid/ready channel interfaces for the request and result beats of the scheduler.
// Depends on nothing beyond the fixed field widths.
interface dtts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  task_slot;
	logic [31:0] new_deadline;
	logic [31:0] repeat_interval;
	logic [31:0] current_time;

	modport source (output valid, opcode, task_slot, new_deadline, repeat_interval,
		current_time, input ready);
	modport sink (input valid, opcode, task_slot, new_deadline, repeat_interval,
		current_time, output ready);
endinterface

interface dtts_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  fired_slot;
	logic        was_cancelled;
	logic [31:0] expiry_time;
	logic [15:0] compare_value;
	logic        pend_request;
	logic        last;

	modport source (output valid, kind, fired_slot, was_cancelled, expiry_time,
		compare_value, pend_request, last, input ready);
	modport sink (input valid, kind, fired_slot, was_cancelled, expiry_time,
		compare_value, pend_request, last, output ready);
endinterface

>>> design/dtts_div.sv
// Restoring divider, one quotient bit per cycle, for skipping missed periods.
// Uses no package items.
module dtts_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo,
	output logic        done
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 6'd32;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

>>> design/dtts_datapath.sv
// Datapath of the scheduler: slot memories, ordered list, cancelled stack, offset,
// configuration registers and the result register. Uses dtts_pkg and dtts_div.
module dtts_datapath #(
	parameter int TASK_SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dtts_pkg::cmd_t  cmd,
	output dtts_pkg::stat_t stat,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [15:0]     cfg_wdata,
	input  logic [1:0]      opcode,
	input  logic [3:0]      task_slot,
	input  logic [31:0]     new_deadline,
	input  logic [31:0]     repeat_interval,
	input  logic [31:0]     current_time,
	input  logic            out_ready,
	output logic            out_valid,
	output logic            kind,
	output logic [3:0]      fired_slot,
	output logic            was_cancelled,
	output logic [31:0]     expiry_time,
	output logic [15:0]     compare_value,
	output logic            pend_request,
	output logic            last
);
	localparam int SW = $clog2(TASK_SLOTS);

	logic [31:0]   dl_mem [TASK_SLOTS];
	logic [31:0]   iv_mem [TASK_SLOTS];
	logic [SW-1:0] ord_q [TASK_SLOTS];
	logic [SW-1:0] stk_q [TASK_SLOTS];
	logic [1:0]    stat_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] fired_q;
	logic [SW:0]   ord_cnt_q;
	logic [SW:0]   stk_cnt_q;
	logic [SW:0]   pos_q;
	logic [31:0]   ofs_q;
	logic [15:0]   spin_q;
	logic [15:0]   reload_q;
	logic [1:0]    op_q;
	logic [3:0]    slot_raw_q;
	logic [31:0]   dl_in_q;
	logic [31:0]   iv_in_q;
	logic [31:0]   now_q;
	logic [SW-1:0] cur_q;
	logic [31:0]   key_q;
	logic [31:0]   rdl_q;
	logic [31:0]   riv_q;
	logic [31:0]   prod_q;
	logic          ov_q;
	logic          kind_q;
	logic [3:0]    slot_out_q;
	logic          canc_q;
	logic [31:0]   exp_q;
	logic [15:0]   cmp_q;
	logic          pend_q;

	logic [SW-1:0] slot_in;
	logic [SW-1:0] pos_idx;
	logic [SW-1:0] ord_at_pos;
	logic [SW-1:0] stk_top;
	logic [SW-1:0] rd_addr;
	logic [31:0]   due_lim;
	logic [31:0]   diff;
	logic [31:0]   quo;
	logic          div_done;
	logic          can_emit;

	assign slot_in    = SW'(slot_raw_q);
	assign pos_idx    = pos_q[SW-1:0];
	assign ord_at_pos = ord_q[pos_idx];
	assign stk_top    = stk_q[SW'(stk_cnt_q - 1'b1)];
	assign rd_addr    = cmd.rd_head ? ord_q[0] : ord_at_pos;
	assign due_lim    = now_q + {16'd0, spin_q};
	assign diff       = rdl_q - ofs_q;
	assign can_emit   = !ov_q || out_ready;

	dtts_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (now_q - key_q - 32'd1),
		.den   (riv_q),
		.quo   (quo),
		.done  (div_done)
	);

	always_comb begin
		stat.op          = op_q;
		stat.slot_ok     = 32'(slot_raw_q) < TASK_SLOTS;
		stat.slot_stat   = stat_q[slot_in];
		stat.pos_end     = pos_q >= ord_cnt_q;
		stat.ord_hit     = (pos_q < ord_cnt_q) && (ord_at_pos == slot_in);
		stat.stk_hit     = (pos_q < stk_cnt_q) && (stk_q[pos_idx] == slot_in);
		stat.stk_empty   = stk_cnt_q == '0;
		stat.fired_pos   = fired_q[ord_at_pos];
		stat.rd_no_later = dtts_pkg::no_later(rdl_q, key_q);
		stat.due         = dtts_pkg::no_later(rdl_q, due_lim);
		stat.iv_zero     = riv_q == '0;
		stat.wrap_need   = (key_q != now_q) && dtts_pkg::no_later(key_q, now_q);
		stat.div_done    = div_done;
		stat.can_emit    = can_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_cnt_q <= '0;
			stk_cnt_q <= '0;
			pos_q     <= '0;
			fired_q   <= '0;
			ofs_q     <= '0;
			spin_q    <= '0;
			reload_q  <= 16'hFFFF;
			ov_q      <= 1'b0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				stat_q[i] <= dtts_pkg::ST_IDLE;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					dtts_pkg::CFG_SPIN:   spin_q   <= cfg_wdata;
					dtts_pkg::CFG_RELOAD: reload_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.clr_fired) begin
				fired_q <= '0;
			end
			if (cmd.ofs_add) begin
				ofs_q <= ofs_q + {16'd0, reload_q} + 32'd1;
			end
			if (cmd.ord_remove) begin
				ord_cnt_q <= ord_cnt_q - 1'b1;
			end else if (cmd.ord_insert) begin
				ord_cnt_q <= ord_cnt_q + 1'b1;
				stat_q[cur_q] <= dtts_pkg::ST_SCHED;
			end
			if (cmd.stk_remove) begin
				stk_cnt_q <= stk_cnt_q - 1'b1;
			end
			if (cmd.stk_push) begin
				stk_cnt_q <= stk_cnt_q + 1'b1;
				stat_q[slot_in] <= dtts_pkg::ST_CANC;
			end
			if (cmd.emit_canc) begin
				stk_cnt_q <= stk_cnt_q - 1'b1;
				stat_q[stk_top] <= dtts_pkg::ST_IDLE;
				fired_q[stk_top] <= 1'b1;
			end
			if (cmd.emit_exp) begin
				fired_q[cur_q] <= 1'b1;
			end
			if (cmd.st_idle_cur) begin
				stat_q[cur_q] <= dtts_pkg::ST_IDLE;
			end
			if (cmd.emit_canc || cmd.emit_exp || cmd.emit_status) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= opcode;
			slot_raw_q <= task_slot;
			dl_in_q    <= new_deadline;
			iv_in_q    <= repeat_interval;
			now_q      <= current_time;
		end
		if (cmd.wr_mem) begin
			dl_mem[slot_in] <= dl_in_q;
			iv_mem[slot_in] <= iv_in_q;
		end
		if (cmd.wr_key) begin
			dl_mem[cur_q] <= key_q;
		end
		if (cmd.rd_pos || cmd.rd_head) begin
			rdl_q <= dl_mem[rd_addr];
			riv_q <= iv_mem[rd_addr];
		end
		if (cmd.set_cur_slot) begin
			cur_q <= slot_in;
			key_q <= dl_in_q;
		end
		if (cmd.set_cur_pos) begin
			cur_q <= ord_at_pos;
		end
		if (cmd.key_add_iv) begin
			key_q <= rdl_q + riv_q;
		end
		if (cmd.mul) begin
			prod_q <= 32'((quo + 32'd1) * riv_q);
		end
		if (cmd.key_add_prod) begin
			key_q <= key_q + prod_q;
		end
		if (cmd.ord_remove) begin
			for (int i = 0; i < TASK_SLOTS - 1; i++) begin
				if (i >= pos_q) begin
					ord_q[i] <= ord_q[i+1];
				end
			end
		end else if (cmd.ord_insert) begin
			for (int i = 1; i < TASK_SLOTS; i++) begin
				if (i > pos_q) begin
					ord_q[i] <= ord_q[i-1];
				end
			end
			ord_q[pos_idx] <= cur_q;
		end
		if (cmd.stk_remove) begin
			for (int i = 0; i < TASK_SLOTS - 1; i++) begin
				if (i >= pos_q) begin
					stk_q[i] <= stk_q[i+1];
				end
			end
		end
		if (cmd.stk_push) begin
			stk_q[SW'(stk_cnt_q)] <= slot_in;
		end
		if (cmd.emit_canc) begin
			kind_q     <= 1'b0;
			slot_out_q <= 4'(stk_top);
			canc_q     <= 1'b1;
			exp_q      <= '0;
			cmp_q      <= '0;
			pend_q     <= 1'b0;
		end else if (cmd.emit_exp) begin
			kind_q     <= 1'b0;
			slot_out_q <= 4'(cur_q);
			canc_q     <= 1'b0;
			exp_q      <= rdl_q;
			cmp_q      <= '0;
			pend_q     <= 1'b0;
		end else if (cmd.emit_status) begin
			kind_q     <= 1'b1;
			slot_out_q <= '0;
			canc_q     <= 1'b0;
			exp_q      <= '0;
			if (ord_cnt_q == '0 || diff > {16'd0, reload_q}) begin
				cmp_q <= '0;
			end else begin
				cmp_q <= diff[15:0];
			end
			pend_q <= (ord_cnt_q != '0) && stat.due;
		end
	end

	assign out_valid     = ov_q;
	assign kind          = kind_q;
	assign fired_slot    = slot_out_q;
	assign was_cancelled = canc_q;
	assign expiry_time   = exp_q;
	assign compare_value = cmp_q;
	assign pend_request  = pend_q;
	assign last          = kind_q;
endmodule

>>> design/dtts_ctrl.sv
// Controller state machine of the scheduler: sequences list scans, inserts, service
// and the closing result. Uses dtts_pkg command and status structures.
module dtts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dtts_pkg::stat_t stat,
	output dtts_pkg::cmd_t  cmd
);
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISP     = 5'd1;
	localparam logic [4:0] S_FIND_ORD = 5'd2;
	localparam logic [4:0] S_FIND_STK = 5'd3;
	localparam logic [4:0] S_WRITE    = 5'd4;
	localparam logic [4:0] S_INS_RD   = 5'd5;
	localparam logic [4:0] S_INS_CMP  = 5'd6;
	localparam logic [4:0] S_INS_PUT  = 5'd7;
	localparam logic [4:0] S_CANC     = 5'd8;
	localparam logic [4:0] S_SV_CANC  = 5'd9;
	localparam logic [4:0] S_SV_SCAN  = 5'd10;
	localparam logic [4:0] S_SV_DUE   = 5'd11;
	localparam logic [4:0] S_SV_WRAP  = 5'd12;
	localparam logic [4:0] S_SV_DIV   = 5'd13;
	localparam logic [4:0] S_SV_MUL   = 5'd14;
	localparam logic [4:0] S_SV_ADD   = 5'd15;
	localparam logic [4:0] S_SV_WB    = 5'd16;
	localparam logic [4:0] S_ST_RD    = 5'd17;
	localparam logic [4:0] S_ST_EMIT  = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.op)
					dtts_pkg::OP_SCHEDULE: begin
						cmd.pos_clr = 1'b1;
						if (!stat.slot_ok) begin
							state_d = S_ST_RD;
						end else if (stat.slot_stat == dtts_pkg::ST_SCHED) begin
							state_d = S_FIND_ORD;
						end else if (stat.slot_stat == dtts_pkg::ST_CANC) begin
							state_d = S_FIND_STK;
						end else begin
							state_d = S_WRITE;
						end
					end
					dtts_pkg::OP_CANCEL: begin
						cmd.pos_clr = 1'b1;
						if (stat.slot_ok && stat.slot_stat == dtts_pkg::ST_SCHED) begin
							state_d = S_CANC;
						end else begin
							state_d = S_ST_RD;
						end
					end
					dtts_pkg::OP_OVERFLOW: begin
						cmd.ofs_add = 1'b1;
						state_d     = S_ST_RD;
					end
					default: begin
						cmd.clr_fired = 1'b1;
						state_d       = S_SV_CANC;
					end
				endcase
			end
			S_FIND_ORD: begin
				if (stat.ord_hit) begin
					cmd.ord_remove = 1'b1;
					state_d        = S_WRITE;
				end else if (stat.pos_end) begin
					state_d = S_WRITE;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			S_FIND_STK: begin
				if (stat.stk_hit) begin
					cmd.stk_remove = 1'b1;
					state_d        = S_WRITE;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			S_WRITE: begin
				cmd.wr_mem       = 1'b1;
				cmd.set_cur_slot = 1'b1;
				cmd.pos_clr      = 1'b1;
				state_d          = S_INS_RD;
			end
			S_INS_RD: begin
				if (stat.pos_end) begin
					state_d = S_INS_PUT;
				end else begin
					cmd.rd_pos = 1'b1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (stat.rd_no_later) begin
					cmd.pos_inc = 1'b1;
					state_d     = S_INS_RD;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				cmd.ord_insert = 1'b1;
				cmd.pos_clr    = 1'b1;
				state_d = (stat.op == dtts_pkg::OP_SERVICE) ? S_SV_SCAN : S_ST_RD;
			end
			S_CANC: begin
				if (stat.ord_hit) begin
					cmd.ord_remove = 1'b1;
					cmd.stk_push   = 1'b1;
					state_d        = S_ST_RD;
				end else if (stat.pos_end) begin
					state_d = S_ST_RD;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			S_SV_CANC: begin
				if (stat.stk_empty) begin
					cmd.pos_clr = 1'b1;
					state_d     = S_SV_SCAN;
				end else if (stat.can_emit) begin
					cmd.emit_canc = 1'b1;
				end
			end
			S_SV_SCAN: begin
				if (stat.pos_end) begin
					state_d = S_ST_RD;
				end else if (stat.fired_pos) begin
					cmd.pos_inc = 1'b1;
				end else begin
					cmd.rd_pos      = 1'b1;
					cmd.set_cur_pos = 1'b1;
					state_d         = S_SV_DUE;
				end
			end
			S_SV_DUE: begin
				if (!stat.due) begin
					state_d = S_ST_RD;
				end else if (stat.can_emit) begin
					cmd.emit_exp   = 1'b1;
					cmd.ord_remove = 1'b1;
					if (stat.iv_zero) begin
						cmd.st_idle_cur = 1'b1;
						cmd.pos_clr     = 1'b1;
						state_d         = S_SV_SCAN;
					end else begin
						cmd.key_add_iv = 1'b1;
						state_d        = S_SV_WRAP;
					end
				end
			end
			S_SV_WRAP: begin
				if (stat.wrap_need) begin
					cmd.div_start = 1'b1;
					state_d       = S_SV_DIV;
				end else begin
					state_d = S_SV_WB;
				end
			end
			S_SV_DIV: begin
				if (stat.div_done) begin
					state_d = S_SV_MUL;
				end
			end
			S_SV_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SV_ADD;
			end
			S_SV_ADD: begin
				cmd.key_add_prod = 1'b1;
				state_d          = S_SV_WB;
			end
			S_SV_WB: begin
				cmd.wr_key  = 1'b1;
				cmd.pos_clr = 1'b1;
				state_d     = S_INS_RD;
			end
			S_ST_RD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_ST_EMIT;
			end
			S_ST_EMIT: begin
				if (stat.can_emit) begin
					cmd.emit_status = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

>>> design/deadline_timer_task_scheduler.sv
// Top level of the deadline timer task scheduler: joins controller and datapath.
// Depends on dtts_pkg, dtts_if, dtts_ctrl and dtts_datapath.
//
// One request beat on req carries an opcode (schedule, cancel, service, overflow)
// with its slot, deadline, interval and present time. The block answers on rsp
// with zero or more fire beats followed by one closing beat (last high) that
// holds the compare value and the pend flag. The configuration port writes the
// spin window (index 0) and the counter reload (index 1); the user is to write them
// only while the block is idle, since the block itself does not enforce this.
// One request is processed at a time; req.ready is high only between requests.
// Cancel and schedule walk the ordered list entry by entry, and schedule then
// re-inserts the slot by a sorted scan. Service emits one fire beat per cancelled
// slot and, per expired slot, does a list scan and a sorted re-insert of periodic
// slots, using the bit-serial divider when missed periods are skipped.
// Reset empties the list and the stack, marks every slot idle and clears the offset.
// A stalled rsp holds the current beat in the output register and the sequence
// pauses at its next result until the beat is taken.
module deadline_timer_task_scheduler #(
	parameter int TASK_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	dtts_req_if.sink    req,
	dtts_rsp_if.source  rsp
);
	dtts_pkg::cmd_t  cmd;
	dtts_pkg::stat_t stat;

	dtts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dtts_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.opcode         (req.opcode),
		.task_slot      (req.task_slot),
		.new_deadline   (req.new_deadline),
		.repeat_interval(req.repeat_interval),
		.current_time   (req.current_time),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.kind           (rsp.kind),
		.fired_slot     (rsp.fired_slot),
		.was_cancelled  (rsp.was_cancelled),
		.expiry_time    (rsp.expiry_time),
		.compare_value  (rsp.compare_value),
		.pend_request   (rsp.pend_request),
		.last           (rsp.last)
	);
endmodule

>>> design/dtts_chk.sv
// Port-level checker for the deadline timer task scheduler, with its bind statement.
// Depends only on the top level's ports.
module dtts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_kind,
	input logic        rsp_canc,
	input logic [31:0] rsp_exp,
	input logic [15:0] rsp_cmp,
	input logic        rsp_pend,
	input logic        rsp_last
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a previous one was in progress");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_exp)
		&& $stable(rsp_cmp))
		else $error("stalled result beat changed");

	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_kind |-> !rsp_last && rsp_cmp == 16'd0 && !rsp_pend)
		else $error("fire beat carries closing fields");

	a_canc_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_canc |-> !rsp_kind && rsp_exp == 32'd0)
		else $error("cancelled fire beat carries an expiry");
endmodule

bind deadline_timer_task_scheduler dtts_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_kind (rsp.kind),
	.rsp_canc (rsp.was_cancelled),
	.rsp_exp  (rsp.expiry_time),
	.rsp_cmp  (rsp.compare_value),
	.rsp_pend (rsp.pend_request),
	.rsp_last (rsp.last)
);

>>> test/tb_deadline_timer_task_scheduler.sv
// Self-checking testbench for deadline_timer_task_scheduler: directed and random
// schedule, cancel, service and overflow requests, checked beat by beat against a predictor.
// Depends on dtts_pkg, dtts_if and the scheduler RTL.
module tb_deadline_timer_task_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  task_slot;
		logic [31:0] new_deadline;
		logic [31:0] repeat_interval;
		logic [31:0] current_time;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  fired_slot;
		logic        was_cancelled;
		logic [31:0] expiry_time;
		logic [15:0] compare_value;
		logic        pend_request;
		logic        last;
	} rsp_t;

	localparam int NSLOTS = 16;
	localparam int STALL_LIMIT = 6000;

	logic clk, arst_n, cfg_we, cfg_idx;
	logic [15:0] cfg_wdata;
	dtts_req_if req();
	dtts_rsp_if rsp();

	deadline_timer_task_scheduler #(.TASK_SLOTS(NSLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .req(req.sink), .rsp(rsp.source)
	);

	req_t pending_reqs[$];
	rsp_t expected_beats[$];
	int errors = 0, beats_seen = 0, reqs_taken = 0, idle_wd = 0;
	int send_idle = 0, recv_idle = 0, hold_left = 0;
	bit req_took = 0, start_hold = 0;
	logic [31:0] now_t = 0;

	logic [15:0] m_spin, m_reload;
	logic [31:0] m_dl[NSLOTS], m_iv[NSLOTS], m_ofs;
	logic [1:0]  m_st[NSLOTS];
	int m_order[NSLOTS], m_ocnt, m_stack[NSLOTS], m_scnt;

	function automatic bit not_after(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return d <= 32'h8000_0000;
	endfunction

	function automatic bit slot_due(int s, logic [31:0] now);
		logic [31:0] lim;
		lim = now + {16'd0, m_spin};
		return not_after(m_dl[s], lim);
	endfunction

	task automatic order_drop_at(int pos);
		for (int i = pos; i + 1 < m_ocnt; i++) m_order[i] = m_order[i + 1];
		m_ocnt--;
	endtask

	task automatic order_add(int s);
		int pos;
		pos = 0;
		while (pos < m_ocnt && not_after(m_dl[m_order[pos]], m_dl[s])) pos++;
		for (int i = m_ocnt; i > pos; i--) m_order[i] = m_order[i - 1];
		m_order[pos] = s;
		m_ocnt++;
		m_st[s] = dtts_pkg::ST_SCHED;
	endtask

	task automatic push_beat(logic k, int s, logic c, logic [31:0] e, logic [15:0] cv,
			logic p, logic l);
		rsp_t b;
		b.kind = k; b.fired_slot = s[3:0]; b.was_cancelled = c; b.expiry_time = e;
		b.compare_value = cv; b.pend_request = p; b.last = l;
		expected_beats.push_back(b);
	endtask

	task automatic predict_schedule(req_t r);
		int s, pos, t, j;
		logic [31:0] cmp, p, d, q;
		bit fired[NSLOTS];
		s = r.task_slot;
		case (r.opcode)
			dtts_pkg::OP_SCHEDULE: begin
				if (m_st[s] == dtts_pkg::ST_SCHED) begin
					for (int i = 0; i < m_ocnt; i++)
						if (m_order[i] == s) begin
							order_drop_at(i);
							break;
						end
				end else if (m_st[s] == dtts_pkg::ST_CANC) begin
					for (int i = 0; i < m_scnt; i++)
						if (m_stack[i] == s) begin
							for (j = i; j + 1 < m_scnt; j++) m_stack[j] = m_stack[j + 1];
							m_scnt--;
							break;
						end
				end
				m_dl[s] = r.new_deadline;
				m_iv[s] = r.repeat_interval;
				order_add(s);
			end
			dtts_pkg::OP_CANCEL: begin
				if (m_st[s] == dtts_pkg::ST_SCHED) begin
					for (int i = 0; i < m_ocnt; i++)
						if (m_order[i] == s) begin
							order_drop_at(i);
							break;
						end
					m_stack[m_scnt++] = s;
					m_st[s] = dtts_pkg::ST_CANC;
				end
			end
			dtts_pkg::OP_OVERFLOW: m_ofs = m_ofs + {16'd0, m_reload} + 32'd1;
			default: begin
				foreach (fired[i]) fired[i] = 0;
				while (m_scnt > 0) begin
					t = m_stack[--m_scnt];
					m_st[t] = dtts_pkg::ST_IDLE;
					fired[t] = 1;
					push_beat(0, t, 1, 0, 0, 0, 0);
				end
				forever begin
					pos = 0;
					while (pos < m_ocnt && fired[m_order[pos]]) pos++;
					if (pos >= m_ocnt) break;
					t = m_order[pos];
					if (!slot_due(t, r.current_time)) break;
					order_drop_at(pos);
					fired[t] = 1;
					push_beat(0, t, 0, m_dl[t], 0, 0, 0);
					if (m_iv[t] != 0) begin
						p = m_iv[t];
						d = m_dl[t] + p;
						if (d != r.current_time && not_after(d, r.current_time)) begin
							q = (r.current_time - d - 32'd1) / p + 32'd1;
							q = q * p;
							d = d + q;
						end
						m_dl[t] = d;
						order_add(t);
					end else begin
						m_st[t] = dtts_pkg::ST_IDLE;
					end
				end
			end
		endcase
		cmp = 0;
		if (m_ocnt > 0) begin
			cmp = m_dl[m_order[0]] - m_ofs;
			if (cmp > {16'd0, m_reload}) cmp = 0;
		end
		push_beat(1, 0, 0, 0, cmp[15:0], (m_ocnt > 0) && slot_due(m_order[0], r.current_time), 1);
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		req_took <= req.valid && req.ready;
		if (req.valid && req.ready) begin
			predict_schedule('{req.opcode, req.task_slot, req.new_deadline,
				req.repeat_interval, req.current_time});
			reqs_taken++;
		end
		if (rsp.valid && rsp.ready) begin
			beats_seen++;
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				rsp_t e;
				e = expected_beats.pop_front();
				if (rsp.kind !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, rsp.kind); errors++;
				end
				if (rsp.fired_slot !== e.fired_slot) begin
					$error("fired_slot exp %0d got %0d", e.fired_slot, rsp.fired_slot); errors++;
				end
				if (rsp.was_cancelled !== e.was_cancelled) begin
					$error("was_cancelled exp %0d got %0d", e.was_cancelled, rsp.was_cancelled);
					errors++;
				end
				if (rsp.expiry_time !== e.expiry_time) begin
					$error("expiry_time exp %h got %h", e.expiry_time, rsp.expiry_time); errors++;
				end
				if (rsp.compare_value !== e.compare_value) begin
					$error("compare_value exp %h got %h", e.compare_value, rsp.compare_value);
					errors++;
				end
				if (rsp.pend_request !== e.pend_request) begin
					$error("pend_request exp %0d got %0d", e.pend_request, rsp.pend_request);
					errors++;
				end
				if (rsp.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, rsp.last); errors++;
				end
			end
		end
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_wd = 0;
		else if (arst_n) idle_wd++;
		if (idle_wd >= STALL_LIMIT) begin
			$display("deadline_timer_task_scheduler regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!req.valid || req_took)) begin
			if ($urandom_range(0, 99) < send_idle || pending_reqs.size() == 0) begin
				req.valid <= 1'b0;
			end else begin
				req_t r;
				r = pending_reqs.pop_front();
				req.valid <= 1'b1;
				{req.opcode, req.task_slot, req.new_deadline, req.repeat_interval,
					req.current_time} <= r;
			end
		end
	end

	always @(negedge clk) begin
		if (start_hold && hold_left == 0) hold_left = 400;
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic add_req(logic [1:0] op, int s, logic [31:0] dl, logic [31:0] iv,
			logic [31:0] now);
		pending_reqs.push_back('{op, s[3:0], dl, iv, now});
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1; cfg_idx = idx; cfg_wdata = val;
		@(negedge clk);
		cfg_we = 0;
		if (idx == dtts_pkg::CFG_SPIN) m_spin = val;
		else m_reload = val;
	endtask

	task automatic drain;
		while (pending_reqs.size() != 0 || req.valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_reqs(int n);
		int w;
		logic [31:0] dl, iv, t;
		repeat (n) begin
			now_t = now_t + $urandom_range(0, 3000);
			w = $urandom_range(0, 99);
			dl = ($urandom_range(0, 9) == 0) ? $urandom : now_t + $urandom_range(0, 6000);
			case ($urandom_range(0, 9))
				0, 1, 2: iv = 0;
				3, 4: iv = $urandom_range(1, 10);
				9: iv = $urandom;
				default: iv = $urandom_range(1, 2000);
			endcase
			t = now_t;
			if ($urandom_range(0, 9) == 0) begin
				now_t = now_t + $urandom_range(0, 32'h7FFF_FFFF);
				t = now_t;
			end else if ($urandom_range(0, 19) == 0) begin
				t = $urandom;
			end
			if (w < 45) begin
				add_req(dtts_pkg::OP_SCHEDULE, $urandom_range(0, 15), dl, iv, t);
			end else if (w < 60) begin
				add_req(dtts_pkg::OP_CANCEL, $urandom_range(0, 15), $urandom, $urandom, t);
			end else if (w < 90) begin
				add_req(dtts_pkg::OP_SERVICE, $urandom_range(0, 15), $urandom, $urandom, t);
			end else begin
				add_req(dtts_pkg::OP_OVERFLOW, $urandom_range(0, 15), $urandom, $urandom, t);
			end
		end
	endtask

	initial begin
		cfg_we = 0; cfg_idx = 0; cfg_wdata = 0;
		req.valid = 0; req.opcode = 0; req.task_slot = 0;
		req.new_deadline = 0; req.repeat_interval = 0; req.current_time = 0;
		rsp.ready = 0;
		m_spin = 0; m_reload = 16'hFFFF; m_ofs = 0; m_ocnt = 0; m_scnt = 0;
		foreach (m_st[i]) begin
			m_st[i] = dtts_pkg::ST_IDLE; m_dl[i] = 0; m_iv[i] = 0;
		end
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n = 1;

		// Ties, extremes, cancel of idle slot, cancel then reschedule, wrap of the order.
		add_req(dtts_pkg::OP_SERVICE, 0, 0, 0, 0);
		add_req(dtts_pkg::OP_CANCEL, 3, 0, 0, 0);
		add_req(dtts_pkg::OP_SCHEDULE, 0, 32'd100, 32'd0, 0);
		add_req(dtts_pkg::OP_SCHEDULE, 1, 32'd100, 32'd0, 0);
		add_req(dtts_pkg::OP_SCHEDULE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		add_req(dtts_pkg::OP_SCHEDULE, 2, 32'h8000_0000, 32'd7, 0);
		add_req(dtts_pkg::OP_SCHEDULE, 3, 32'd50, 32'd10, 0);
		add_req(dtts_pkg::OP_CANCEL, 1, 0, 0, 0);
		add_req(dtts_pkg::OP_SCHEDULE, 1, 32'd60, 32'd0, 0);
		add_req(dtts_pkg::OP_CANCEL, 0, 0, 0, 0);
		add_req(dtts_pkg::OP_CANCEL, 2, 0, 0, 0);
		add_req(dtts_pkg::OP_SERVICE, 0, 0, 0, 32'd100);
		add_req(dtts_pkg::OP_OVERFLOW, 0, 0, 0, 32'd100);
		add_req(dtts_pkg::OP_SERVICE, 0, 0, 0, 32'd5000);
		add_req(dtts_pkg::OP_SCHEDULE, 4, 32'd10, 32'd1, 32'd0);
		add_req(dtts_pkg::OP_SERVICE, 0, 0, 0, 32'h7FFF_FFFF);
		add_req(dtts_pkg::OP_OVERFLOW, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(dtts_pkg::OP_SERVICE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		write_reg(dtts_pkg::CFG_SPIN, 16'd0);
		write_reg(dtts_pkg::CFG_RELOAD, 16'hFFFF);
		send_idle = 19; recv_idle = 69;
		random_reqs(140);
		drain();

		write_reg(dtts_pkg::CFG_SPIN, 16'hFFFF);
		write_reg(dtts_pkg::CFG_RELOAD, 16'd1);
		send_idle = 69; recv_idle = 19;
		random_reqs(140);
		drain();

		write_reg(dtts_pkg::CFG_SPIN, 16'($urandom_range(0, 4000)));
		write_reg(dtts_pkg::CFG_RELOAD, 16'($urandom_range(1, 65535)));
		send_idle = 0; recv_idle = 0;
		start_hold = 1;
		random_reqs(140);
		@(negedge clk);
		start_hold = 0;
		drain();
		repeat (200) @(posedge clk);

		$display("Covered %0d requests and %0d result beats over three register settings.",
			reqs_taken, beats_seen);
		if (errors == 0 && expected_beats.size() == 0)
			$display("deadline_timer_task_scheduler regression: pass");
		else
			$display("deadline_timer_task_scheduler regression: fail");
		$finish;
	end
endmodule
